[hw/rtl/hrp_pkg.sv]
// shared types, codes and helpers for the hex record parser
`default_nettype none

package hrp_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0] CHAR_COLON         = 8'h3A;
	localparam logic [7:0] CMDLINE_TYPE_RESET = 8'd6;

	localparam logic [7:0] REC_PAYLOAD   = 8'd0;
	localparam logic [7:0] REC_END       = 8'd1;
	localparam logic [7:0] REC_EXT_SEG   = 8'd2;
	localparam logic [7:0] REC_START_SEG = 8'd3;
	localparam logic [7:0] REC_EXT_LIN   = 8'd4;
	localparam logic [7:0] REC_START_LIN = 8'd5;

	localparam logic [1:0] EV_PAYLOAD = 2'd0;
	localparam logic [1:0] EV_ACCEPT  = 2'd1;
	localparam logic [1:0] EV_REJECT  = 2'd2;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_EARLY_END = 3'd1;
	localparam logic [2:0] ERR_BAD_CHAR  = 3'd2;
	localparam logic [2:0] ERR_BAD_COUNT = 3'd3;
	localparam logic [2:0] ERR_BAD_TYPE  = 3'd4;
	localparam logic [2:0] ERR_BAD_CKSUM = 3'd5;

	typedef enum logic [3:0] {
		PH_WAIT,
		PH_COUNT,
		PH_OFFH,
		PH_OFFL,
		PH_TYPE,
		PH_PDATA,
		PH_PSEG,
		PH_PLIN,
		PH_PSTART,
		PH_CKSUM,
		PH_DRAIN
	} phase_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [2:0]  error_code;
		logic [7:0]  record_type;
		logic [7:0]  data_byte;
		logic [7:0]  byte_index;
		logic [15:0] load_offset;
		logic [31:0] base_address;
		logic [31:0] start_address;
		logic        last;
	} result_t;

	function automatic logic is_hex(input logic [7:0] c);
		logic ok;
		ok = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
		return ok;
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] v;
		if (c inside {[8'h30:8'h39]}) begin
			v = c[3:0];
		end else begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/hrp_step.sv]
// record state and per-character decode, up to two results per request
`default_nettype none

module hrp_step (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire logic [7:0]      char_code,
	input  wire logic            end_of_record,
	input  wire logic            cfg_wr_en,
	input  wire logic [7:0]      cfg_wr_data,
	output hrp_pkg::result_t     res0,
	output hrp_pkg::result_t     res1,
	output logic [1:0]           res_cnt
);
	import hrp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  hi_q, hi_d;
	logic        pend_q, pend_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  count_q, count_d;
	logic [15:0] offset_q, offset_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  bytes_q, bytes_d;
	logic [31:0] acc_q, acc_d;
	logic [31:0] base_q, base_d;
	logic [31:0] start_q, start_d;
	logic [7:0]  cmd_type_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_type_q <= CMDLINE_TYPE_RESET;
		end else if (cfg_wr_en) begin
			cmd_type_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT;
			hi_q     <= '0;
			pend_q   <= 1'b0;
			sum_q    <= '0;
			count_q  <= '0;
			offset_q <= '0;
			type_q   <= '0;
			bytes_q  <= '0;
			acc_q    <= '0;
			base_q   <= '0;
			start_q  <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			hi_q     <= hi_d;
			pend_q   <= pend_d;
			sum_q    <= sum_d;
			count_q  <= count_d;
			offset_q <= offset_d;
			type_q   <= type_d;
			bytes_q  <= bytes_d;
			acc_q    <= acc_d;
			base_q   <= base_d;
			start_q  <= start_d;
		end
	end

	always_comb begin
		logic       hex_ok;
		logic [7:0] b;
		logic [7:0] bytes_inc;
		logic       pay;
		logic       fin;
		logic       closed;
		logic [1:0] fin_ev;
		logic [2:0] fin_err;
		logic [2:0] terr;
		phase_t     tnext;

		hex_ok    = is_hex(char_code);
		b         = {hi_q, hex_val(char_code)};
		bytes_inc = bytes_q + 8'd1;
		pay       = 1'b0;
		fin       = 1'b0;
		closed    = 1'b0;
		fin_ev    = EV_REJECT;
		fin_err   = ERR_NONE;
		terr      = ERR_NONE;
		tnext     = PH_CKSUM;

		phase_d  = phase_q;
		hi_d     = hi_q;
		pend_d   = pend_q;
		sum_d    = sum_q;
		count_d  = count_q;
		offset_d = offset_q;
		type_d   = type_q;
		bytes_d  = bytes_q;
		acc_d    = acc_q;
		base_d   = base_q;
		start_d  = start_q;

		case (phase_q)
			PH_DRAIN: begin
			end
			PH_WAIT: begin
				if (end_of_record) begin
					fin     = 1'b1;
					fin_err = ERR_EARLY_END;
				end else if (char_code == CHAR_COLON) begin
					hi_d     = '0;
					pend_d   = 1'b0;
					sum_d    = '0;
					count_d  = '0;
					offset_d = '0;
					type_d   = '0;
					bytes_d  = '0;
					acc_d    = '0;
					phase_d  = PH_COUNT;
				end
			end
			default: begin
				if (!pend_q) begin
					if (end_of_record) begin
						fin     = 1'b1;
						fin_err = ERR_EARLY_END;
						closed  = 1'b1;
					end else if (!hex_ok) begin
						fin     = 1'b1;
						fin_err = ERR_BAD_CHAR;
						closed  = 1'b1;
					end else begin
						hi_d   = hex_val(char_code);
						pend_d = 1'b1;
					end
				end else if (!hex_ok) begin
					pend_d  = 1'b0;
					fin     = 1'b1;
					fin_err = ERR_BAD_CHAR;
					closed  = 1'b1;
				end else begin
					pend_d = 1'b0;
					sum_d  = sum_q + b;
					case (phase_q)
						PH_COUNT: begin
							count_d = b;
							phase_d = PH_OFFH;
						end
						PH_OFFH: begin
							offset_d = {b, 8'h00};
							phase_d  = PH_OFFL;
						end
						PH_OFFL: begin
							offset_d = {offset_q[15:8], b};
							phase_d  = PH_TYPE;
						end
						PH_TYPE: begin
							type_d = b;
							if (b == REC_PAYLOAD || b == cmd_type_q) begin
								tnext = PH_PDATA;
							end else if (b == REC_END) begin
								if (count_q != 8'd0) terr = ERR_BAD_COUNT;
							end else if (b == REC_EXT_SEG || b == REC_EXT_LIN) begin
								if (count_q != 8'd2) terr = ERR_BAD_COUNT;
								tnext = (b == REC_EXT_SEG) ? PH_PSEG : PH_PLIN;
							end else if (b == REC_START_SEG || b == REC_START_LIN) begin
								if (count_q != 8'd4) terr = ERR_BAD_COUNT;
								tnext = PH_PSTART;
							end else begin
								terr = ERR_BAD_TYPE;
							end
							if (terr != ERR_NONE) begin
								fin     = 1'b1;
								fin_err = terr;
								closed  = 1'b1;
							end else begin
								acc_d   = '0;
								bytes_d = '0;
								phase_d = (count_q == 8'd0) ? PH_CKSUM : tnext;
							end
						end
						PH_PDATA, PH_PSEG, PH_PLIN, PH_PSTART: begin
							acc_d = {acc_q[23:0], b};
							if (phase_q == PH_PSEG && bytes_q == 8'd1) begin
								base_d = {12'h000, acc_d[15:0], 4'h0};
							end
							if (phase_q == PH_PLIN && bytes_q == 8'd1) begin
								base_d = {acc_d[15:0], 16'h0000};
							end
							if (phase_q == PH_PSTART && bytes_q == 8'd3) begin
								start_d = acc_d;
							end
							pay     = (phase_q == PH_PDATA);
							bytes_d = bytes_inc;
							if (bytes_inc == count_q) phase_d = PH_CKSUM;
						end
						default: begin
							fin    = 1'b1;
							closed = 1'b1;
							if (sum_d != 8'd0) begin
								fin_err = ERR_BAD_CKSUM;
							end else begin
								fin_ev = EV_ACCEPT;
							end
						end
					endcase
					if (!closed && end_of_record) begin
						fin     = 1'b1;
						fin_err = ERR_EARLY_END;
						closed  = 1'b1;
					end
				end
				if (closed && !end_of_record) phase_d = PH_DRAIN;
			end
		endcase

		// both results of one request share the record fields seen here
		res0.record_type   = type_d;
		res0.load_offset   = offset_d;
		res0.base_address  = base_d;
		res0.start_address = start_d;
		res1.record_type   = type_d;
		res1.load_offset   = offset_d;
		res1.base_address  = base_d;
		res1.start_address = start_d;

		res1.event_res  = fin_ev;
		res1.error_code = fin_err;
		res1.data_byte  = '0;
		res1.byte_index = '0;
		res1.last       = 1'b1;

		if (pay) begin
			res0.event_res  = EV_PAYLOAD;
			res0.error_code = ERR_NONE;
			res0.data_byte  = b;
			res0.byte_index = bytes_q;
			res0.last       = !fin;
		end else begin
			res0.event_res  = fin_ev;
			res0.error_code = fin_err;
			res0.data_byte  = '0;
			res0.byte_index = '0;
			res0.last       = 1'b1;
		end
		res_cnt = {1'b0, pay} + {1'b0, fin};

		if (end_of_record) begin
			hi_d     = '0;
			pend_d   = 1'b0;
			sum_d    = '0;
			count_d  = '0;
			offset_d = '0;
			type_d   = '0;
			bytes_d  = '0;
			acc_d    = '0;
			phase_d  = PH_WAIT;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/hrp_res_fifo.sv]
// result queue, up to two pushes and one pop per cycle
`default_nettype none

module hrp_res_fifo #(
	parameter int unsigned DEPTH = hrp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [1:0]        push_cnt,
	input  wire hrp_pkg::result_t  push0,
	input  wire hrp_pkg::result_t  push1,
	output logic                   room2,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output hrp_pkg::result_t       out_res
);
	import hrp_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

	result_t       mem [DEPTH];
	logic [PW-1:0] wr_q, rd_q, wr_p1, wr_p2, rd_p1;
	logic [CW-1:0] cnt_q;
	logic          pop;

	function automatic logic [PW-1:0] inc_ptr(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		r = (p == LAST_IDX) ? '0 : p + PW'(1);
		return r;
	endfunction

	assign wr_p1     = inc_ptr(wr_q);
	assign wr_p2     = inc_ptr(wr_p1);
	assign rd_p1     = inc_ptr(rd_q);
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign room2     = (cnt_q <= ROOM_MAX);
	assign out_res   = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) mem[wr_q] <= push0;
		if (push_cnt == 2'd2) mem[wr_p1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			case (push_cnt)
				2'd1:    wr_q <= wr_p1;
				2'd2:    wr_q <= wr_p2;
				default: wr_q <= wr_q;
			endcase
			if (pop) rd_q <= rd_p1;
			cnt_q <= cnt_q + CW'(push_cnt) - CW'(pop);
		end
	end

endmodule

`default_nettype wire

[hw/rtl/hex_record_parser_core.sv]
// hex record parser top level: input register, decode step, result queue
// a taken request passes the input register and the decode step, and its results are written into the result queue
// throughput: one request per cycle while the queue keeps room for two results
// a request with two results is offered on the result side as two separate results, one per pop
// reset: arst_n clears all record state, base and start addresses and the queue
// the command-line type register resets to 6
`default_nettype none

module hex_record_parser_core #(
	parameter int unsigned QUEUE_DEPTH = hrp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_code,
	input  wire logic        end_of_record,
	input  wire logic        cfg_wr_en,
	input  wire logic [7:0]  cfg_wr_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       event_res,
	output logic [2:0]       error_code,
	output logic [7:0]       record_type,
	output logic [7:0]       data_byte,
	output logic [7:0]       byte_index,
	output logic [15:0]      load_offset,
	output logic [31:0]      base_address,
	output logic [31:0]      start_address,
	output logic             last
);
	import hrp_pkg::*;

	logic       v_s1;
	logic [7:0] char_s1;
	logic       eor_s1;
	logic       adv;
	logic       room2;
	logic [1:0] res_cnt;
	logic [1:0] push_cnt;
	result_t    res0, res1, head;

	assign adv      = v_s1 && room2;
	assign in_ready = !v_s1 || adv;
	assign push_cnt = adv ? res_cnt : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			eor_s1  <= end_of_record;
		end
	end

	hrp_step u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (adv),
		.char_code     (char_s1),
		.end_of_record (eor_s1),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.res0          (res0),
		.res1          (res1),
		.res_cnt       (res_cnt)
	);

	hrp_res_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push0     (res0),
		.push1     (res1),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (head)
	);

	assign event_res     = head.event_res;
	assign error_code    = head.error_code;
	assign record_type   = head.record_type;
	assign data_byte     = head.data_byte;
	assign byte_index    = head.byte_index;
	assign load_offset   = head.load_offset;
	assign base_address  = head.base_address;
	assign start_address = head.start_address;
	assign last          = head.last;

endmodule

`default_nettype wire

[hw/rtl/hrp_checker.sv]
// port-level checks for the hex record parser, bound to the top level
`default_nettype none

module hrp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  event_res,
	input wire logic [2:0]  error_code,
	input wire logic [7:0]  data_byte,
	input wire logic        last
);
	import hrp_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(error_code)
			&& $stable(data_byte) && $stable(last))
		else $error("result changed while stalled");

	a_reject_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_REJECT |-> error_code != ERR_NONE && last)
		else $error("reject without error code");

	a_ok_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_ACCEPT || event_res == EV_PAYLOAD)
			|-> error_code == ERR_NONE)
		else $error("error code on non-reject event");

	a_close_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_ACCEPT |-> last && data_byte == 8'h00)
		else $error("accept not final or carries data");

endmodule

bind hex_record_parser_core hrp_checker u_hrp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.event_res  (event_res),
	.error_code (error_code),
	.data_byte  (data_byte),
	.last       (last)
);

`default_nettype wire

[dv/tb_hex_record_parser_core.sv]
// testbench for hex_record_parser_core: directed and random hex records checked against a predictor
`timescale 1ns / 1ps

module tb_hex_record_parser_core;
	import hrp_pkg::*;

	localparam int SETTLE_CYCLES = 6;
	localparam int IDLE_LIMIT    = 4000;
	localparam int LONG_HOLD     = 300;
	localparam int PRINT_LIMIT   = 40;

	localparam int SINK_FREE = 0;
	localparam int SINK_COIN = 1;
	localparam int SINK_SLOW = 2;
	localparam int SINK_BEAT = 3;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic [7:0]  char_code     = 8'd0;
	logic        end_of_record = 1'b0;
	logic        cfg_wr_en     = 1'b0;
	logic [7:0]  cfg_wr_data   = 8'd0;
	logic        out_ready     = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [1:0]  event_res;
	logic [2:0]  error_code;
	logic [7:0]  record_type;
	logic [7:0]  data_byte;
	logic [7:0]  byte_index;
	logic [15:0] load_offset;
	logic [31:0] base_address;
	logic [31:0] start_address;
	logic        last;

	// predictor state
	logic [7:0]  cmd_type     = CMDLINE_TYPE_RESET;
	phase_t      rec_phase    = PH_WAIT;
	logic [3:0]  hi_digit     = 4'd0;
	logic        digit_held   = 1'b0;
	logic [7:0]  check_sum    = 8'd0;
	logic [7:0]  rec_count    = 8'd0;
	logic [15:0] rec_offset   = 16'd0;
	logic [7:0]  rec_type     = 8'd0;
	logic [7:0]  payload_pos  = 8'd0;
	logic [31:0] field_shift  = 32'd0;
	logic [31:0] load_base    = 32'd0;
	logic [31:0] entry_point  = 32'd0;

	result_t     expected_events[$];
	logic [7:0]  line_buf[$];
	int          mismatch_count = 0;
	int          burst_left     = 0;
	logic        steady         = 1'b0;
	int          hold_request   = 0;

	hex_record_parser_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_code    (char_code),
		.end_of_record(end_of_record),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_res    (event_res),
		.error_code   (error_code),
		.record_type  (record_type),
		.data_byte    (data_byte),
		.byte_index   (byte_index),
		.load_offset  (load_offset),
		.base_address (base_address),
		.start_address(start_address),
		.last         (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [4:0] digit_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
		if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
		if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
		return 5'h10;
	endfunction

	function automatic result_t snapshot_event(input logic [1:0] ev, input logic [2:0] err,
			input logic [7:0] data, input logic [7:0] idx);
		result_t r;
		r.event_res     = ev;
		r.error_code    = err;
		r.record_type   = rec_type;
		r.data_byte     = data;
		r.byte_index    = idx;
		r.load_offset   = rec_offset;
		r.base_address  = load_base;
		r.start_address = entry_point;
		r.last          = 1'b0;
		return r;
	endfunction

	function automatic void clear_line_state();
		hi_digit    = 4'd0;
		digit_held  = 1'b0;
		check_sum   = 8'd0;
		rec_count   = 8'd0;
		rec_offset  = 16'd0;
		rec_type    = 8'd0;
		payload_pos = 8'd0;
		field_shift = 32'd0;
	endfunction

	function automatic void decode_char(input logic [7:0] c, input logic eor);
		result_t    produced[$];
		logic [4:0] dig;
		logic [7:0] b;
		logic [2:0] err;
		phase_t     nxt;
		logic       closed;
		closed = 1'b0;
		if (rec_phase == PH_WAIT) begin
			if (eor) begin
				produced.push_back(snapshot_event(EV_REJECT, ERR_EARLY_END, 8'd0, 8'd0));
			end else if (c == CHAR_COLON) begin
				clear_line_state();
				rec_phase = PH_COUNT;
			end
		end else if (rec_phase != PH_DRAIN) begin
			dig = digit_value(c);
			if (!digit_held) begin
				if (eor) begin
					produced.push_back(snapshot_event(EV_REJECT, ERR_EARLY_END, 8'd0, 8'd0));
					closed = 1'b1;
				end else if (dig[4]) begin
					produced.push_back(snapshot_event(EV_REJECT, ERR_BAD_CHAR, 8'd0, 8'd0));
					closed = 1'b1;
				end else begin
					hi_digit   = dig[3:0];
					digit_held = 1'b1;
				end
			end else if (dig[4]) begin
				digit_held = 1'b0;
				produced.push_back(snapshot_event(EV_REJECT, ERR_BAD_CHAR, 8'd0, 8'd0));
				closed = 1'b1;
			end else begin
				b          = {hi_digit, dig[3:0]};
				digit_held = 1'b0;
				check_sum  = check_sum + b;
				case (rec_phase)
				PH_COUNT: begin
					rec_count = b;
					rec_phase = PH_OFFH;
				end
				PH_OFFH: begin
					rec_offset = {b, 8'h00};
					rec_phase  = PH_OFFL;
				end
				PH_OFFL: begin
					rec_offset[7:0] = b;
					rec_phase       = PH_TYPE;
				end
				PH_TYPE: begin
					err      = ERR_NONE;
					nxt      = PH_CKSUM;
					rec_type = b;
					if (b == REC_PAYLOAD || b == cmd_type) begin
						nxt = PH_PDATA;
					end else if (b == REC_END) begin
						if (rec_count != 8'd0) err = ERR_BAD_COUNT;
					end else if (b == REC_EXT_SEG || b == REC_EXT_LIN) begin
						if (rec_count != 8'd2) err = ERR_BAD_COUNT;
						if (b == REC_EXT_SEG) begin
							nxt = PH_PSEG;
						end else begin
							nxt = PH_PLIN;
						end
					end else if (b == REC_START_SEG || b == REC_START_LIN) begin
						if (rec_count != 8'd4) err = ERR_BAD_COUNT;
						nxt = PH_PSTART;
					end else begin
						err = ERR_BAD_TYPE;
					end
					if (err != ERR_NONE) begin
						produced.push_back(snapshot_event(EV_REJECT, err, 8'd0, 8'd0));
						closed = 1'b1;
					end else begin
						field_shift = 32'd0;
						payload_pos = 8'd0;
						if (rec_count == 8'd0) begin
							rec_phase = PH_CKSUM;
						end else begin
							rec_phase = nxt;
						end
					end
				end
				PH_PDATA, PH_PSEG, PH_PLIN, PH_PSTART: begin
					field_shift = {field_shift[23:0], b};
					if (rec_phase == PH_PSEG && payload_pos == 8'd1)
						load_base = {12'h000, field_shift[15:0], 4'h0};
					if (rec_phase == PH_PLIN && payload_pos == 8'd1)
						load_base = {field_shift[15:0], 16'h0000};
					if (rec_phase == PH_PSTART && payload_pos == 8'd3)
						entry_point = field_shift;
					if (rec_phase == PH_PDATA)
						produced.push_back(snapshot_event(EV_PAYLOAD, ERR_NONE, b, payload_pos));
					payload_pos = payload_pos + 8'd1;
					if (payload_pos == rec_count) rec_phase = PH_CKSUM;
				end
				default: begin
					if (check_sum != 8'd0) begin
						produced.push_back(snapshot_event(EV_REJECT, ERR_BAD_CKSUM, 8'd0, 8'd0));
					end else begin
						produced.push_back(snapshot_event(EV_ACCEPT, ERR_NONE, 8'd0, 8'd0));
					end
					closed = 1'b1;
				end
				endcase
				if (!closed && eor) begin
					produced.push_back(snapshot_event(EV_REJECT, ERR_EARLY_END, 8'd0, 8'd0));
					closed = 1'b1;
				end
			end
			if (closed && !eor) rec_phase = PH_DRAIN;
		end
		if (eor) begin
			clear_line_state();
			rec_phase = PH_WAIT;
		end
		if (produced.size() != 0) produced[produced.size() - 1].last = 1'b1;
		foreach (produced[i]) expected_events.push_back(produced[i]);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
	endtask

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {event_res, error_code, record_type, data_byte, byte_index, load_offset,
				base_address, start_address, last};
			if (expected_events.size() == 0) begin
				report_mismatch("result with nothing pending, event_res", 32'd0,
					32'(got.event_res));
			end else begin
				want = expected_events.pop_front();
				if (got.event_res !== want.event_res)
					report_mismatch("event_res", 32'(want.event_res), 32'(got.event_res));
				if (got.error_code !== want.error_code)
					report_mismatch("error_code", 32'(want.error_code), 32'(got.error_code));
				if (got.record_type !== want.record_type)
					report_mismatch("record_type", 32'(want.record_type),
						32'(got.record_type));
				if (got.data_byte !== want.data_byte)
					report_mismatch("data_byte", 32'(want.data_byte), 32'(got.data_byte));
				if (got.byte_index !== want.byte_index)
					report_mismatch("byte_index", 32'(want.byte_index), 32'(got.byte_index));
				if (got.load_offset !== want.load_offset)
					report_mismatch("load_offset", 32'(want.load_offset),
						32'(got.load_offset));
				if (got.base_address !== want.base_address)
					report_mismatch("base_address", want.base_address, got.base_address);
				if (got.start_address !== want.start_address)
					report_mismatch("start_address", want.start_address, got.start_address);
				if (got.last !== want.last)
					report_mismatch("last", 32'(want.last), 32'(got.last));
			end
		end
	end

	// output side stall pattern, with an occasional long hold
	always @(posedge clk) begin : sink_pattern
		int mode;
		int mode_left;
		int hold_left;
		int beat;
		if (hold_left == 0 && hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		beat++;
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				mode      = $urandom_range(SINK_FREE, SINK_BEAT);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (mode)
			SINK_FREE: out_ready <= 1'b1;
			SINK_COIN: out_ready <= 1'($urandom_range(0, 1));
			SINK_SLOW: out_ready <= ($urandom_range(0, 3) == 0);
			default:   out_ready <= (beat % 3 != 0);
			endcase
		end
	end

	always @(posedge clk) begin : watchdog
		int idle_cycles;
		if (arst_n && ((in_valid && in_ready) || (out_valid && out_ready))) begin
			idle_cycles = 0;
		end else if (arst_n) begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("hex_record_parser_core: mismatch");
			$finish;
		end
	end

	task automatic send_char(input logic [7:0] c, input logic eor);
		in_valid      <= 1'b1;
		char_code     <= c;
		end_of_record <= eor;
		do begin
			@(posedge clk);
		end while (!in_ready);
		decode_char(c, eor);
		if (!steady) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				if ($urandom_range(0, 3) == 0) begin
					burst_left = $urandom_range(30, 90);
				end else begin
					burst_left = $urandom_range(0, 12);
				end
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_events.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cmdline_type(input logic [7:0] value);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cmd_type = value;
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'("0" + n);
		if ($urandom_range(0, 1) == 0) return 8'("A" + n - 8'd10);
		return 8'("a" + n - 8'd10);
	endfunction

	function automatic void push_hex(input logic [7:0] b);
		line_buf.push_back(hex_char(b[7:4]));
		line_buf.push_back(hex_char(b[3:0]));
	endfunction

	function automatic logic [7:0] noise_char();
		case ($urandom_range(0, 2))
		0: return hex_char(4'($urandom));
		1: return CHAR_COLON;
		default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] junk_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom);
		end while (c == CHAR_COLON);
		return c;
	endfunction

	function automatic logic [7:0] nonhex_char();
		logic [7:0] c;
		logic [4:0] d;
		do begin
			c = 8'($urandom);
			d = digit_value(c);
		end while (!d[4]);
		return c;
	endfunction

	// one line of text: mostly well-formed records, some broken, some noise
	function automatic void build_line();
		int         pick;
		int         cnt;
		int         colon_at;
		int         pos;
		logic [7:0] rtype;
		logic [7:0] sum;
		logic [7:0] b;
		logic [15:0] ofs;
		line_buf.delete();
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			repeat ($urandom_range(1, 12)) line_buf.push_back(noise_char());
			return;
		end
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) line_buf.push_back(junk_char());
		end
		colon_at = line_buf.size();
		line_buf.push_back(CHAR_COLON);
		if ($urandom_range(0, 39) == 0) begin
			cnt = $urandom_range(9, 255);
		end else begin
			cnt = $urandom_range(0, 8);
		end
		pick = $urandom_range(0, 9);
		case (pick)
		0, 1, 2: rtype = REC_PAYLOAD;
		3: rtype = cmd_type;
		4: begin
			rtype = REC_END;
			cnt   = 0;
		end
		5: begin
			rtype = REC_EXT_SEG;
			cnt   = 2;
		end
		6: begin
			rtype = REC_EXT_LIN;
			cnt   = 2;
		end
		7: begin
			rtype = ($urandom_range(0, 1) == 0) ? REC_START_SEG : REC_START_LIN;
			cnt   = 4;
		end
		default: begin
			rtype = 8'($urandom);
			cnt   = $urandom_range(0, 6);
		end
		endcase
		if (pick >= 4 && pick <= 7 && $urandom_range(0, 9) == 0) cnt = $urandom_range(0, 6);
		ofs = 16'($urandom);
		sum = 8'(cnt) + ofs[15:8] + ofs[7:0] + rtype;
		push_hex(8'(cnt));
		push_hex(ofs[15:8]);
		push_hex(ofs[7:0]);
		push_hex(rtype);
		repeat (cnt) begin
			b   = 8'($urandom);
			sum = sum + b;
			push_hex(b);
		end
		sum = -sum;
		if ($urandom_range(0, 9) == 0) sum = sum + 8'($urandom_range(1, 255));
		push_hex(sum);
		pick = $urandom_range(0, 11);
		if (pick == 0) begin
			pos = $urandom_range(colon_at, line_buf.size() - 1);
			line_buf = line_buf[0:pos];
		end else if (pick == 1) begin
			pos = $urandom_range(colon_at + 1, line_buf.size() - 1);
			line_buf[pos] = nonhex_char();
		end else if (pick == 2) begin
			repeat ($urandom_range(1, 3)) line_buf.push_back(noise_char());
		end
	endfunction

	task automatic run_records(input int budget);
		int sent;
		sent = 0;
		while (sent < budget) begin
			build_line();
			foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
			sent += line_buf.size();
		end
	endtask

	task automatic test_directed_cases();
		send_char(8'h00, 1'b1);
		send_text(":G");
		send_char(CHAR_COLON, 1'b0);
		send_char("G", 1'b0);
		send_char(8'hFF, 1'b1);
		send_text(":0:");
		send_text(":00000001FF");
		send_text(":020000");
	endtask

	task automatic test_random_records();
		run_records(250);
	endtask

	task automatic test_cmdline_type();
		write_cmdline_type(8'd0);
		run_records(110);
		write_cmdline_type(8'd255);
		run_records(110);
		write_cmdline_type(8'($urandom_range(1, 5)));
		run_records(110);
		write_cmdline_type(8'($urandom_range(7, 254)));
		run_records(110);
		write_cmdline_type(CMDLINE_TYPE_RESET);
		run_records(110);
	endtask

	// output held off while requests keep coming, so the input stalls
	task automatic test_input_backpressure();
		hold_request = LONG_HOLD;
		steady = 1'b1;
		run_records(130);
		steady = 1'b0;
	endtask

	task automatic test_pause_until_drained();
		run_records(50);
		wait_drained();
		run_records(50);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_records();
		test_cmdline_type();
		test_input_backpressure();
		test_pause_until_drained();
		wait_drained();
		if (mismatch_count == 0 && expected_events.size() == 0) begin
			$display("hex_record_parser_core: match");
		end else begin
			$display("hex_record_parser_core: mismatch");
		end
		$finish;
	end

endmodule
